// ===== rtl/esys_pkg.sv =====
// ----------------------------------------------------------------------------
// esys_pkg
// Shared constants and types for the 2x2 eigen-system pipeline.
// ----------------------------------------------------------------------------
package esys_pkg;

  // Default widths: Q7.8 matrix elements, Q1.14 unit vectors
  localparam int IN_WIDTH_DEF = 16;
  localparam int VEC_FRAC_DEF = 14;

  // Per-stage control handed to every cell of a chain
  typedef struct packed {
    logic en;   // whole pipeline advances this cycle
    logic vld;  // the incoming slot holds a transaction
  } stage_ctl_t;

endpackage

// ===== rtl/eigen_system_2x2_top.sv =====
// ----------------------------------------------------------------------------
// eigen_system_2x2_top
// Eigenvalues and unit eigenvectors of a real 2x2 matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one matrix [[a,b],[c,d]] per transaction and returns one result per
// transaction, in order: lambda_hi/lo = (trace +/- sqrt(disc))/2 with the
// division truncated toward zero, and for each eigenvalue L the vector
// (b, L-a) scaled to unit length with VEC_FRAC fraction bits. A negative
// discriminant is clamped to zero and flagged on complex_roots_o. A zero
// vector yields (1,0) for lambda_hi and (0,1) for lambda_lo. The pipeline
// accepts one transaction every cycle while the output is not stalled; its
// depth is set by three chains of one-bit cells: a discriminant square root
// of IN_WIDTH+1 cells, a two-lane magnitude square root of IN_WIDTH+2 cells
// and a four-lane divider of VEC_FRAC+1 cells. The whole pipeline holds
// when the output register is full and not taken, so in_ready_o follows
// out_ready_i whenever a result is waiting.
// ----------------------------------------------------------------------------
module eigen_system_2x2_top #(
  parameter int IN_WIDTH = esys_pkg::IN_WIDTH_DEF,
  parameter int VEC_FRAC = esys_pkg::VEC_FRAC_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [IN_WIDTH-1:0] m_a_i,
  input  logic signed [IN_WIDTH-1:0] m_b_i,
  input  logic signed [IN_WIDTH-1:0] m_c_i,
  input  logic signed [IN_WIDTH-1:0] m_d_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [IN_WIDTH+1:0] lambda_hi_o,
  output logic signed [IN_WIDTH+1:0] lambda_lo_o,
  output logic signed [VEC_FRAC+1:0] vec_hi_x_o,
  output logic signed [VEC_FRAC+1:0] vec_hi_y_o,
  output logic signed [VEC_FRAC+1:0] vec_lo_x_o,
  output logic signed [VEC_FRAC+1:0] vec_lo_y_o,
  output logic                       complex_roots_o
);

  localparam int W   = IN_WIDTH;
  localparam int LW  = W + 2;          // eigenvalue width
  localparam int VW  = VEC_FRAC + 2;   // vector component width
  localparam int DN  = 2 * W + 2;      // discriminant radicand, even
  localparam int R1  = W + 1;          // discriminant root width
  localparam int SN  = 2 * W + 4;      // squared magnitude radicand, even
  localparam int R2  = W + 2;          // magnitude width
  localparam int QW  = VEC_FRAC + 1;   // quotient width
  localparam int P1  = 3 * W + 2;
  localparam int P2  = 2 * LW + W + 2 * (W + 3) + 1;
  localparam int P3  = 2 * LW + 7;
  localparam logic [QW-1:0] ONE = {1'b1, {VEC_FRAC{1'b0}}};

  logic pipe_en;
  assign pipe_en    = ~out_valid_o | out_ready_i;
  assign in_ready_o = pipe_en;

  // --------------------------------------------------------------------------
  // Stage 1: products for the discriminant
  // --------------------------------------------------------------------------
  logic signed [W:0]      diff_c;
  logic signed [W:0]      s1_tr_q;
  logic signed [2*W+1:0]  s1_dsq_q;
  logic signed [2*W-1:0]  s1_bc_q;
  logic signed [W-1:0]    s1_a_q, s1_b_q;
  logic                   s1_vld_q;

  assign diff_c = (W+1)'(m_a_i) - (W+1)'(m_d_i);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_dsq_q <= (2*W+2)'(diff_c) * (2*W+2)'(diff_c);
      s1_bc_q  <= m_b_i * m_c_i;
      s1_tr_q  <= (W+1)'(m_a_i) + (W+1)'(m_d_i);
      s1_a_q   <= m_a_i;
      s1_b_q   <= m_b_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: discriminant, clamped at zero
  // --------------------------------------------------------------------------
  logic signed [2*W+2:0] disc_c;
  logic [DN-1:0]         s2_rad_q;
  logic [P1-1:0]         s2_side_q;
  logic                  s2_vld_q;

  assign disc_c = (2*W+3)'(s1_dsq_q) + ((2*W+3)'(s1_bc_q) <<< 2);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_rad_q  <= disc_c[2*W+2] ? '0 : disc_c[DN-1:0];
      s2_side_q <= {s1_tr_q, s1_a_q, s1_b_q, disc_c[2*W+2]};
    end
  end

  // --------------------------------------------------------------------------
  // Discriminant square root chain
  // --------------------------------------------------------------------------
  logic [DN-1:0]          c1_rad  [R1+1][1];
  logic [R1+1:0]          c1_rem  [R1+1][1];
  logic [R1-1:0]          c1_root [R1+1][1];
  logic [P1-1:0]          c1_side [R1+1];
  logic                   c1_vld  [R1+1];
  esys_pkg::stage_ctl_t   c1_ctl  [R1];

  assign c1_rad[0][0]  = s2_rad_q;
  assign c1_rem[0][0]  = '0;
  assign c1_root[0][0] = '0;
  assign c1_side[0]    = s2_side_q;
  assign c1_vld[0]     = s2_vld_q;

  for (genvar i = 0; i < R1; i++) begin : g_sqrt1
    assign c1_ctl[i] = '{en: pipe_en, vld: c1_vld[i]};
    esys_sqrt_cell #(.LANES(1), .NB(DN), .RTW(R1), .PW(P1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c1_ctl[i]),
      .rad_i  (c1_rad[i]),
      .rem_i  (c1_rem[i]),
      .root_i (c1_root[i]),
      .side_i (c1_side[i]),
      .vld_o  (c1_vld[i+1]),
      .rad_o  (c1_rad[i+1]),
      .rem_o  (c1_rem[i+1]),
      .root_o (c1_root[i+1]),
      .side_o (c1_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: eigenvalues and the free vector components
  // --------------------------------------------------------------------------
  function automatic logic signed [LW-1:0] sat_lam(input logic signed [W+2:0] x);
    logic signed [W+2:0] rnd, hv;
    rnd = x + $signed({{(W+2){1'b0}}, x[W+2]});
    hv  = rnd >>> 1;
    if (hv[W+2] != hv[W+1]) begin
      return hv[W+2] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
    end
    return hv[LW-1:0];
  endfunction

  logic signed [W:0]    p1_tr;
  logic signed [W-1:0]  p1_a, p1_b;
  logic                 p1_cplx;
  logic signed [W+2:0]  root_s, sum_p, sum_m;
  logic signed [LW-1:0] lhi_c, llo_c;

  assign {p1_tr, p1_a, p1_b, p1_cplx} = c1_side[R1];
  assign root_s = $signed({2'b00, c1_root[R1][0]});
  assign sum_p  = (W+3)'(p1_tr) + root_s;
  assign sum_m  = (W+3)'(p1_tr) - root_s;
  assign lhi_c  = sat_lam(sum_p);
  assign llo_c  = sat_lam(sum_m);

  logic signed [LW-1:0] s3_lhi_q, s3_llo_q;
  logic signed [W+2:0]  s3_vyh_q, s3_vyl_q;
  logic signed [W-1:0]  s3_b_q;
  logic                 s3_cplx_q, s3_vld_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_lhi_q  <= lhi_c;
      s3_llo_q  <= llo_c;
      s3_vyh_q  <= (W+3)'(lhi_c) - (W+3)'(p1_a);
      s3_vyl_q  <= (W+3)'(llo_c) - (W+3)'(p1_a);
      s3_b_q    <= p1_b;
      s3_cplx_q <= p1_cplx;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared vector lengths
  // --------------------------------------------------------------------------
  logic signed [2*W+5:0] bsq_c, vhsq_c, vlsq_c, msh_c, msl_c;
  logic [SN-1:0]         s4_rad_q [2];
  logic [P2-1:0]         s4_side_q;
  logic                  s4_vld_q;

  assign bsq_c  = (2*W+6)'(s3_b_q) * (2*W+6)'(s3_b_q);
  assign vhsq_c = (2*W+6)'(s3_vyh_q) * (2*W+6)'(s3_vyh_q);
  assign vlsq_c = (2*W+6)'(s3_vyl_q) * (2*W+6)'(s3_vyl_q);
  assign msh_c  = bsq_c + vhsq_c;
  assign msl_c  = bsq_c + vlsq_c;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_rad_q[0] <= msh_c[SN-1:0];
      s4_rad_q[1] <= msl_c[SN-1:0];
      s4_side_q   <= {s3_lhi_q, s3_llo_q, s3_b_q, s3_vyh_q, s3_vyl_q, s3_cplx_q};
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude square root chain, one lane per eigenvector
  // --------------------------------------------------------------------------
  logic [SN-1:0]          c2_rad  [R2+1][2];
  logic [R2+1:0]          c2_rem  [R2+1][2];
  logic [R2-1:0]          c2_root [R2+1][2];
  logic [P2-1:0]          c2_side [R2+1];
  logic                   c2_vld  [R2+1];
  esys_pkg::stage_ctl_t   c2_ctl  [R2];

  assign c2_rad[0]  = s4_rad_q;
  assign c2_rem[0]  = '{default: '0};
  assign c2_root[0] = '{default: '0};
  assign c2_side[0] = s4_side_q;
  assign c2_vld[0]  = s4_vld_q;

  for (genvar i = 0; i < R2; i++) begin : g_sqrt2
    assign c2_ctl[i] = '{en: pipe_en, vld: c2_vld[i]};
    esys_sqrt_cell #(.LANES(2), .NB(SN), .RTW(R2), .PW(P2)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c2_ctl[i]),
      .rad_i  (c2_rad[i]),
      .rem_i  (c2_rem[i]),
      .root_i (c2_root[i]),
      .side_i (c2_side[i]),
      .vld_o  (c2_vld[i+1]),
      .rad_o  (c2_rad[i+1]),
      .rem_o  (c2_rem[i+1]),
      .root_o (c2_root[i+1]),
      .side_o (c2_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 5: magnitudes and signs set up for the divider
  // --------------------------------------------------------------------------
  function automatic logic [R2-1:0] abs_m(input logic signed [W+2:0] x);
    logic signed [W+2:0] n;
    n = -x;
    return x[W+2] ? n[R2-1:0] : x[R2-1:0];
  endfunction

  logic signed [LW-1:0] p2_lhi, p2_llo;
  logic signed [W-1:0]  p2_b;
  logic signed [W+2:0]  p2_vyh, p2_vyl;
  logic                 p2_cplx;
  logic [R2-1:0]        mag_h, mag_l, abs_b;

  assign {p2_lhi, p2_llo, p2_b, p2_vyh, p2_vyl, p2_cplx} = c2_side[R2];
  assign mag_h = c2_root[R2][0];
  assign mag_l = c2_root[R2][1];
  assign abs_b = abs_m((W+3)'(p2_b));

  logic [R2:0]   s5_rem_q [4];
  logic [R2-1:0] s5_den_q [4];
  logic [P3-1:0] s5_side_q;
  logic          s5_vld_q;

  // lanes: 0 hi x, 1 hi y, 2 lo x, 3 lo y
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_rem_q[0] <= {1'b0, abs_b};
      s5_rem_q[1] <= {1'b0, abs_m(p2_vyh)};
      s5_rem_q[2] <= {1'b0, abs_b};
      s5_rem_q[3] <= {1'b0, abs_m(p2_vyl)};
      s5_den_q[0] <= mag_h;
      s5_den_q[1] <= mag_h;
      s5_den_q[2] <= mag_l;
      s5_den_q[3] <= mag_l;
      s5_side_q   <= {p2_lhi, p2_llo, p2_vyl[W+2], p2_b[W-1], p2_vyh[W+2], p2_b[W-1],
                      (mag_h == '0), (mag_l == '0), p2_cplx};
    end
  end

  // --------------------------------------------------------------------------
  // Normalizing divider chain, four lanes
  // --------------------------------------------------------------------------
  logic [R2:0]            c3_rem  [QW+1][4];
  logic [R2-1:0]          c3_den  [QW+1][4];
  logic [QW-1:0]          c3_quo  [QW+1][4];
  logic [P3-1:0]          c3_side [QW+1];
  logic                   c3_vld  [QW+1];
  esys_pkg::stage_ctl_t   c3_ctl  [QW];

  assign c3_rem[0]  = s5_rem_q;
  assign c3_den[0]  = s5_den_q;
  assign c3_quo[0]  = '{default: '0};
  assign c3_side[0] = s5_side_q;
  assign c3_vld[0]  = s5_vld_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    assign c3_ctl[i] = '{en: pipe_en, vld: c3_vld[i]};
    esys_div_cell #(.LANES(4), .DW(R2), .QW(QW), .PW(P3)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c3_ctl[i]),
      .rem_i  (c3_rem[i]),
      .den_i  (c3_den[i]),
      .quo_i  (c3_quo[i]),
      .side_i (c3_side[i]),
      .vld_o  (c3_vld[i+1]),
      .rem_o  (c3_rem[i+1]),
      .den_o  (c3_den[i+1]),
      .quo_o  (c3_quo[i+1]),
      .side_o (c3_side[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register: sign, saturate to one, zero-vector fallback
  // --------------------------------------------------------------------------
  logic signed [LW-1:0] p3_lhi, p3_llo;
  logic [3:0]           p3_neg;
  logic                 p3_zh, p3_zl, p3_cplx;
  logic signed [VW-1:0] comp_c [4];

  assign {p3_lhi, p3_llo, p3_neg, p3_zh, p3_zl, p3_cplx} = c3_side[QW];

  for (genvar k = 0; k < 4; k++) begin : g_comp
    logic [QW-1:0]        qs;
    logic signed [VW-1:0] pos;
    assign qs        = (c3_quo[QW][k] > ONE) ? ONE : c3_quo[QW][k];
    assign pos       = $signed({1'b0, qs});
    assign comp_c[k] = p3_neg[k] ? -pos : pos;
  end

  logic signed [LW-1:0] lhi_q, llo_q;
  logic signed [VW-1:0] hx_q, hy_q, lx_q, ly_q;
  logic                 cplx_q, out_valid_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lhi_q  <= p3_lhi;
      llo_q  <= p3_llo;
      hx_q   <= p3_zh ? $signed({1'b0, ONE}) : comp_c[0];
      hy_q   <= p3_zh ? '0 : comp_c[1];
      lx_q   <= p3_zl ? '0 : comp_c[2];
      ly_q   <= p3_zl ? $signed({1'b0, ONE}) : comp_c[3];
      cplx_q <= p3_cplx;
    end
  end

  // Valid bits of the stage registers outside the cell chains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= c1_vld[R1];
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= c2_vld[R2];
      out_valid_q <= c3_vld[QW];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lambda_hi_o     = lhi_q;
  assign lambda_lo_o     = llo_q;
  assign vec_hi_x_o      = hx_q;
  assign vec_hi_y_o      = hy_q;
  assign vec_lo_x_o      = lx_q;
  assign vec_lo_y_o      = ly_q;
  assign complex_roots_o = cplx_q;

`ifndef SYNTHESIS
  // clamped discriminant means a zero root: both eigenvalues coincide
  a_cplx_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complex_roots_o |-> lambda_hi_o == lambda_lo_o)
    else $error("complex roots with distinct eigenvalues");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lambda_hi_o >= lambda_lo_o)
    else $error("eigenvalues out of order");

  a_unit_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vec_hi_x_o <= $signed({1'b0, ONE}) &&
                    vec_hi_x_o >= -$signed({1'b0, ONE}) &&
                    vec_lo_y_o <= $signed({1'b0, ONE}) &&
                    vec_lo_y_o >= -$signed({1'b0, ONE}))
    else $error("unit vector component above one");
`endif

endmodule

// ===== rtl/esys_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// esys_sqrt_cell
// One step of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module esys_sqrt_cell #(
  parameter int LANES = 1,
  parameter int NB    = 4,
  parameter int RTW   = 2,
  parameter int PW    = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esys_pkg::stage_ctl_t    ctl_i,
  input  logic [NB-1:0]           rad_i  [LANES],
  input  logic [RTW+1:0]          rem_i  [LANES],
  input  logic [RTW-1:0]          root_i [LANES],
  input  logic [PW-1:0]           side_i,
  output logic                    vld_o,
  output logic [NB-1:0]           rad_o  [LANES],
  output logic [RTW+1:0]          rem_o  [LANES],
  output logic [RTW-1:0]          root_o [LANES],
  output logic [PW-1:0]           side_o
);

  logic          vld_q;
  logic [PW-1:0] side_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [RTW+1:0] rem4, trial, rem_d, rem_q;
    logic [RTW-1:0] root_d, root_q;
    logic [NB-1:0]  rad_d, rad_q;
    logic           ge;

    always_comb begin
      rem4   = {rem_i[l][RTW-1:0], rad_i[l][NB-1:NB-2]};
      trial  = {root_i[l], 2'b01};
      ge     = (rem4 >= trial);
      rem_d  = ge ? (rem4 - trial) : rem4;
      root_d = {root_i[l][RTW-2:0], ge};
      rad_d  = {rad_i[l][NB-3:0], 2'b00};
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= rad_d;
      end
    end

    assign rem_o[l]  = rem_q;
    assign root_o[l] = root_q;
    assign rad_o[l]  = rad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;

endmodule

// ===== rtl/esys_div_cell.sv =====
// ----------------------------------------------------------------------------
// esys_div_cell
// One step of a restoring divider: compare, subtract, one quotient bit.
// ----------------------------------------------------------------------------
module esys_div_cell #(
  parameter int LANES = 1,
  parameter int DW    = 4,
  parameter int QW    = 2,
  parameter int PW    = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esys_pkg::stage_ctl_t    ctl_i,
  input  logic [DW:0]             rem_i [LANES],
  input  logic [DW-1:0]           den_i [LANES],
  input  logic [QW-1:0]           quo_i [LANES],
  input  logic [PW-1:0]           side_i,
  output logic                    vld_o,
  output logic [DW:0]             rem_o [LANES],
  output logic [DW-1:0]           den_o [LANES],
  output logic [QW-1:0]           quo_o [LANES],
  output logic [PW-1:0]           side_o
);

  logic          vld_q;
  logic [PW-1:0] side_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DW:0]   diff, rem_d, rem_q;
    logic [DW-1:0] den_q;
    logic [QW-1:0] quo_d, quo_q;
    logic          ge;

    always_comb begin
      ge    = (rem_i[l] >= {1'b0, den_i[l]});
      diff  = ge ? (rem_i[l] - {1'b0, den_i[l]}) : rem_i[l];
      // remainder stays below the divisor, so the shift never overflows
      rem_d = {diff[DW-1:0], 1'b0};
      quo_d = {quo_i[l][QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q <= rem_d;
        den_q <= den_i[l];
        quo_q <= quo_d;
      end
    end

    assign rem_o[l] = rem_q;
    assign den_o[l] = den_q;
    assign quo_o[l] = quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 eigen-system pipeline.
// ----------------------------------------------------------------------------
// Matrices go in as valid/ready transactions from a queue. Each accepted
// matrix is run through a local fixed-point eigen solver and the expected
// eigenvalues, unit vectors and complex flag are queued. The monitor checks
// every result transaction against the oldest entry, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IW  = esys_pkg::IN_WIDTH_DEF;
  localparam int VF  = esys_pkg::VEC_FRAC_DEF;
  localparam int LW  = IW + 2;
  localparam int VW  = VF + 2;
  localparam int LATENCY   = 2 * IW + VF + 10;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic signed [IW-1:0] a, b, c, d;
  } matrix_t;

  typedef struct packed {
    logic signed [LW-1:0] lam_hi, lam_lo;
    logic signed [VW-1:0] hx, hy, lx, ly;
    logic                 cplx;
  } eig_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic signed [IW-1:0] m_a_i = '0, m_b_i = '0, m_c_i = '0, m_d_i = '0;
  logic in_ready_o, out_valid_o, complex_roots_o;
  logic signed [LW-1:0] lambda_hi_o, lambda_lo_o;
  logic signed [VW-1:0] vec_hi_x_o, vec_hi_y_o, vec_lo_x_o, vec_lo_y_o;

  matrix_t matrix_q[$];
  eig_t    eig_q[$];
  int      n_err = 0;
  bit      stim_done = 1'b0;
  bit      hold_send = 1'b0;
  int      wdog = 0;

  always #5 clk_i = ~clk_i;

  eigen_system_2x2_top u_top (.*);

  // Bit-serial integer square root, truncated.
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Scale one component to Q1.14, saturating at one.
  function automatic longint scale_comp(longint v, longint mag);
    longint q;
    q = (abs64(v) << VF) / mag;
    if (q > (64'sd1 << VF)) q = 64'sd1 << VF;
    return (v < 0) ? -q : q;
  endfunction

  function automatic void normalize(longint vx, longint vy, longint fx, longint fy,
                                    output longint ox, output longint oy);
    longint mag;
    mag = longint'(isqrt(abs64(vx) * abs64(vx) + abs64(vy) * abs64(vy)));
    if (mag == 0) begin
      ox = fx; oy = fy;
    end else begin
      ox = scale_comp(vx, mag);
      oy = scale_comp(vy, mag);
    end
  endfunction

  function automatic longint sat_lam(longint v);
    longint hi;
    hi = (64'sd1 << (LW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic eig_t solve_eigen(matrix_t m);
    longint a, b, c, d, disc, root, lhi, llo, hx, hy, lx, ly;
    eig_t e;
    a = m.a; b = m.b; c = m.c; d = m.d;
    disc = (a - d) * (a - d) + 4 * b * c;
    e.cplx = disc < 0;
    if (disc < 0) disc = 0;
    root = longint'(isqrt(disc));
    lhi = sat_lam((a + d + root) / 2);  // SV division truncates toward zero
    llo = sat_lam((a + d - root) / 2);
    normalize(b, lhi - a, 64'sd1 << VF, 0, hx, hy);
    normalize(b, llo - a, 0, 64'sd1 << VF, lx, ly);
    e.lam_hi = lhi[LW-1:0]; e.lam_lo = llo[LW-1:0];
    e.hx = hx[VW-1:0]; e.hy = hy[VW-1:0];
    e.lx = lx[VW-1:0]; e.ly = ly[VW-1:0];
    return e;
  endfunction

  function automatic logic signed [IW-1:0] rand_elem(int mode);
    case (mode)
      0:       return IW'($urandom);
      1:       return IW'($urandom_range(0, 512)) - IW'(256);  // small values
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 9);
    m.a = rand_elem(kind < 5 ? 0 : (kind < 8 ? 1 : $urandom_range(0, 3)));
    m.b = rand_elem(kind < 5 ? 0 : (kind < 8 ? 1 : $urandom_range(0, 3)));
    m.c = rand_elem(kind < 5 ? 0 : (kind < 8 ? 1 : $urandom_range(0, 3)));
    m.d = rand_elem(kind < 5 ? 0 : (kind < 8 ? 1 : $urandom_range(0, 3)));
    if (kind == 9) m.c = -m.b;     // rotation-like: complex roots likely
    if (kind == 8) m.b = '0;       // triangular: zero vectors likely
    return m;
  endfunction

  // Stimulus: directed corners first, then random matrices.
  initial begin
    matrix_t m;
    logic signed [IW-1:0] ext[4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    matrix_q.push_back('{16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100}); // identity
    matrix_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}); // zero
    matrix_q.push_back('{16'sh0000, 16'sh0100, 16'shff00, 16'sh0000}); // rotation
    matrix_q.push_back('{16'sh0200, 16'sh0000, 16'sh0000, 16'sh0100}); // diagonal
    matrix_q.push_back('{16'sh0100, 16'sh0000, 16'sh0000, 16'sh0200});
    matrix_q.push_back('{16'sh0100, 16'sh0001, 16'sh0000, 16'sh0100});
    foreach (ext[i]) foreach (ext[j]) begin
      m.a = ext[i]; m.d = ext[j]; m.b = ext[(i + j) % 4]; m.c = ext[(i + 3 * j) % 4];
      matrix_q.push_back(m);
    end
    matrix_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    matrix_q.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    wait (rst_ni);
    for (int i = 0; i < 900; i++) begin
      while (matrix_q.size() > 4) @(posedge clk_i);
      if (i == 450) begin
        // let the queue empty, then drain the pipeline completely
        while (matrix_q.size() != 0) @(posedge clk_i);
        hold_send = 1'b1;
        @(posedge clk_i);
        while (in_valid_i || eig_q.size() != 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      matrix_q.push_back(rand_matrix());
    end
    while (matrix_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Driver: one matrix per transaction, random gap before each one.
  int send_gap = 0;
  bit burst_mode = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        eig_q.push_back(solve_eigen('{m_a_i, m_b_i, m_c_i, m_d_i}));
        send_gap = burst_mode ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 63) == 0) burst_mode = ~burst_mode;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the pending transaction unchanged
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (matrix_q.size() != 0 && !hold_send) begin
        m_a_i <= matrix_q[0].a; m_b_i <= matrix_q[0].b;
        m_c_i <= matrix_q[0].c; m_d_i <= matrix_q[0].d;
        void'(matrix_q.pop_front());
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  int stall = 0;
  always @(posedge clk_i) begin
    eig_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (eig_q.size() == 0) begin
          $error("result with no matrix pending");
          n_err++;
        end else begin
          e = eig_q.pop_front();
          if (lambda_hi_o !== e.lam_hi) begin
            $error("lambda_hi exp %0d got %0d", e.lam_hi, lambda_hi_o); n_err++;
          end
          if (lambda_lo_o !== e.lam_lo) begin
            $error("lambda_lo exp %0d got %0d", e.lam_lo, lambda_lo_o); n_err++;
          end
          if (vec_hi_x_o !== e.hx) begin
            $error("vec_hi_x exp %0d got %0d", e.hx, vec_hi_x_o); n_err++;
          end
          if (vec_hi_y_o !== e.hy) begin
            $error("vec_hi_y exp %0d got %0d", e.hy, vec_hi_y_o); n_err++;
          end
          if (vec_lo_x_o !== e.lx) begin
            $error("vec_lo_x exp %0d got %0d", e.lx, vec_lo_x_o); n_err++;
          end
          if (vec_lo_y_o !== e.ly) begin
            $error("vec_lo_y exp %0d got %0d", e.ly, vec_lo_y_o); n_err++;
          end
          if (complex_roots_o !== e.cplx) begin
            $error("complex_roots exp %0d got %0d", e.cplx, complex_roots_o); n_err++;
          end
        end
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (out_valid_o && out_ready_i && stall > 0) begin
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
    else wdog <= wdog + 1;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && eig_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk_i);
      end
      begin
        wait (rst_ni && wdog >= WDOG_MAX);
        $display("DONE: errors detected");
        $finish;
      end
    join_any
    if (n_err == 0 && eig_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
